[rtl/edfq_pkg.sv]
// ----------------------------------------------------------------------------
// EDF ready queue package
// Shared types and constants for the earliest-deadline-first ready set.
// ----------------------------------------------------------------------------
package edfq_pkg;

  localparam int MAX_TASK_COUNT = 16;
  localparam int NULL_TASK_ID   = 0;
  localparam int KEY_WIDTH      = 32;

  localparam int ID_W    = 4;
  localparam int IN_KEY_W = 32;
  localparam int CNT_W   = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SELECT = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_DONE = 2'd2
  } state_t;

  // Control from sequencer to every cell
  typedef struct packed {
    logic load;   // broadcast insert into one cell
    logic clear;  // drop one cell's present bit
    logic shift;  // rotate the ring one place
  } cell_ctrl_t;

endpackage

[rtl/edfq_cell.sv]
// ----------------------------------------------------------------------------
// EDF ready queue cell
// Holds one slot of the ring: present bit, id and key; passes to its neighbor.
// ----------------------------------------------------------------------------
module edfq_cell #(
  parameter int ID_W  = 4,
  parameter int KEY_W = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  edfq_pkg::cell_ctrl_t ctrl,
  input  logic                 sel_load,
  input  logic                 sel_clear,
  input  logic [KEY_W-1:0]     load_key,
  input  logic                 prev_vld,
  input  logic [ID_W-1:0]      prev_id,
  input  logic [KEY_W-1:0]     prev_key,
  input  logic [ID_W-1:0]      init_id,
  output logic                 vld,
  output logic [ID_W-1:0]      id,
  output logic [KEY_W-1:0]     key
);

  logic             vld_r, vld_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;

  // Shift from neighbor, else load or clear own slot
  always_comb begin
    vld_nxt = vld_r;
    id_nxt  = id_r;
    key_nxt = key_r;
    if (ctrl.shift) begin
      vld_nxt = prev_vld;
      id_nxt  = prev_id;
      key_nxt = prev_key;
    end else if (ctrl.load && sel_load) begin
      vld_nxt = 1'b1;
      key_nxt = load_key;
    end else if (ctrl.clear && sel_clear) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      id_r  <= init_id;
    end else begin
      vld_r <= vld_nxt;
      id_r  <= id_nxt;
    end
    key_r <= key_nxt;
  end

  assign vld = vld_r;
  assign id  = id_r;
  assign key = key_r;

endmodule

[rtl/edf_ready_queue_select.sv]
// ----------------------------------------------------------------------------
// EDF ready queue select
// Ready set of tasks with deadline keys; insert, remove, select earliest.
// ----------------------------------------------------------------------------
// Usage: one request enters on the in_ stream (op, task_id, deadline_key),
// one result leaves on the out_ stream per request, in order.
// Tasks live in a ring of MAX_TASK_COUNT cells, each holding its id, present
// bit and key. Insert and remove address a cell directly (accept, then the
// DONE state, then result register). Select rotates the ring one full turn,
// one entry per cycle, past a single comparator at the ring head, tracking
// the best key and lowest id, then writes the result in DONE. After the turn
// every cell sits where it began, so the winner is cleared by id.
// Reset empties the set; keys are undefined until inserted.
// One request is worked at a time. While the receiver stalls, the result
// stays in the output register and in_tready stays low until it is taken.
// ----------------------------------------------------------------------------
module edf_ready_queue_select #(
  parameter int MAX_TASK_COUNT = edfq_pkg::MAX_TASK_COUNT,
  parameter int NULL_TASK_ID   = edfq_pkg::NULL_TASK_ID,
  parameter int KEY_WIDTH      = edfq_pkg::KEY_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [1:0] op, [5:2] task_id, [37:6] deadline_key
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [3:0] chosen_task, [4] idle, [5] status,
                                  // [10:6] ready_count
);

  localparam int SLOT_W = (MAX_TASK_COUNT > 1) ? $clog2(MAX_TASK_COUNT) : 1;
  localparam int CW     = $clog2(MAX_TASK_COUNT + 1);
  localparam int ID_W   = edfq_pkg::ID_W;
  localparam int KW     = KEY_WIDTH;

  edfq_pkg::state_t state_r, state_nxt;

  // Request registers
  logic [1:0]      op_r;
  logic [ID_W-1:0] tid_r;
  logic [KW-1:0]   lkey_r;

  logic [CW-1:0]   total_r;
  logic [CW-1:0]   scan_cnt_r;
  logic            best_fnd_r;
  logic [SLOT_W-1:0] best_id_r;
  logic [KW-1:0]   best_key_r;

  logic            ovld_r;
  logic [ID_W-1:0] ochosen_r, ochosen_nxt;
  logic            oidle_r, ostat_r;
  logic            oidle_nxt, ostat_nxt;
  logic [CW-1:0]   ocnt_r, ocnt_nxt;

  logic [MAX_TASK_COUNT-1:0]  cvld;
  logic [SLOT_W-1:0]          cid  [MAX_TASK_COUNT];
  logic [KW-1:0]              ckey [MAX_TASK_COUNT];

  edfq_pkg::cell_ctrl_t ctrl;
  logic accept_in, id_ok, hit, scan_last;
  logic [SLOT_W-1:0] tslot;

  assign accept_in = in_tvalid && in_tready;
  assign in_tready = (state_r == edfq_pkg::ST_IDLE) && !ovld_r;
  assign tslot     = SLOT_W'(tid_r);
  assign id_ok     = (32'(tid_r) < 32'(MAX_TASK_COUNT));
  assign hit       = id_ok && cvld[tslot];
  assign scan_last = (scan_cnt_r == CW'(MAX_TASK_COUNT - 1));

  // Ring of cells; cell 0 is the head, fed back from the tail
  for (genvar g = 0; g < MAX_TASK_COUNT; g++) begin : g_cell
    localparam int P = (g == 0) ? MAX_TASK_COUNT - 1 : g - 1;
    edfq_cell #(.ID_W(SLOT_W), .KEY_W(KW)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .sel_load  (tslot == SLOT_W'(g)),
      .sel_clear (((op_r == edfq_pkg::OP_SELECT) ? best_id_r : tslot) == SLOT_W'(g)),
      .load_key  (lkey_r),
      .prev_vld  (cvld[P]),
      .prev_id   (cid[P]),
      .prev_key  (ckey[P]),
      .init_id   (SLOT_W'(g)),
      .vld       (cvld[g]),
      .id        (cid[g]),
      .key       (ckey[g])
    );
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      edfq_pkg::ST_IDLE: if (accept_in) begin
        state_nxt = (edfq_pkg::op_t'(in_tdata[1:0]) == edfq_pkg::OP_SELECT) ?
                    edfq_pkg::ST_SCAN : edfq_pkg::ST_DONE;
      end
      edfq_pkg::ST_SCAN: if (scan_last) state_nxt = edfq_pkg::ST_DONE;
      edfq_pkg::ST_DONE: state_nxt = edfq_pkg::ST_IDLE;
      default: state_nxt = edfq_pkg::ST_IDLE;
    endcase
  end

  // Cell controls
  always_comb begin
    ctrl = '0;
    unique case (state_r)
      edfq_pkg::ST_SCAN: ctrl.shift = 1'b1;
      edfq_pkg::ST_DONE: begin
        case (op_r)
          edfq_pkg::OP_INSERT: ctrl.load  = id_ok && !cvld[tslot];
          edfq_pkg::OP_REMOVE: ctrl.clear = hit;
          edfq_pkg::OP_SELECT: ctrl.clear = best_fnd_r;
          default: ctrl = '0;
        endcase
      end
      default: ctrl = '0;
    endcase
  end

  // Result fields for the request in hand
  always_comb begin
    ochosen_nxt = ID_W'(NULL_TASK_ID);
    oidle_nxt   = 1'b0;
    ostat_nxt   = 1'b0;
    ocnt_nxt    = total_r;
    if (ctrl.load) ocnt_nxt = total_r + CW'(1);
    else if (ctrl.clear) ocnt_nxt = total_r - CW'(1);
    case (op_r)
      edfq_pkg::OP_INSERT: ostat_nxt = !ctrl.load;
      edfq_pkg::OP_REMOVE: ostat_nxt = !hit;
      edfq_pkg::OP_SELECT: begin
        if (best_fnd_r) ochosen_nxt = ID_W'(best_id_r);
        else oidle_nxt = 1'b1;
      end
      default: ostat_nxt = 1'b1;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= edfq_pkg::ST_IDLE;
      total_r    <= '0;
      ovld_r     <= 1'b0;
      scan_cnt_r <= '0;
      best_fnd_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept_in) begin
        scan_cnt_r <= '0;
        best_fnd_r <= 1'b0;
      end
      // Compare the head cell against the running best
      if (state_r == edfq_pkg::ST_SCAN) begin
        scan_cnt_r <= scan_cnt_r + CW'(1);
        if (cvld[0] && (!best_fnd_r || ckey[0] < best_key_r ||
            (ckey[0] == best_key_r && cid[0] < best_id_r))) begin
          best_fnd_r <= 1'b1;
        end
      end
      if (state_r == edfq_pkg::ST_DONE) begin
        ovld_r  <= 1'b1;
        total_r <= ocnt_nxt;
      end else if (out_tvalid && out_tready) begin
        ovld_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept_in) begin
      op_r   <= in_tdata[1:0];
      tid_r  <= in_tdata[5:2];
      lkey_r <= KW'(in_tdata[6 +: edfq_pkg::IN_KEY_W]);
    end
    if (state_r == edfq_pkg::ST_SCAN && cvld[0] && (!best_fnd_r ||
        ckey[0] < best_key_r || (ckey[0] == best_key_r && cid[0] < best_id_r))) begin
      best_id_r  <= cid[0];
      best_key_r <= ckey[0];
    end
    if (state_r == edfq_pkg::ST_DONE) begin
      ochosen_r <= ochosen_nxt;
      oidle_r   <= oidle_nxt;
      ostat_r   <= ostat_nxt;
      ocnt_r    <= ocnt_nxt;
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = {5'd0, 5'(ocnt_r), ostat_r, oidle_r, ochosen_r};

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(total_r) <= 32'(MAX_TASK_COUNT))
    else $error("ready count beyond task count");
  a_count_bits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == edfq_pkg::ST_IDLE |-> 32'(total_r) == 32'($countones(cvld)))
    else $error("ready count disagrees with present bits");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != edfq_pkg::ST_IDLE |-> !in_tready)
    else $error("request taken while busy");
  a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == edfq_pkg::ST_DONE |=> out_tvalid)
    else $error("result missing after completion");

endmodule
